@@ rtl/core/wvcs_pkg.sv @@
// ----------------------------------------------------------------------------
// wvcs_pkg
// Types, constants and the arctangent table shared by the wind vane smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package wvcs_pkg;

  // defaults for the top level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ENCODER_BITS_DEF = 14;

  // field widths
  localparam int DEG_W   = 9;    // whole degrees, 0..359
  localparam int SM_W    = 16;   // 1/128 degree
  localparam int SHIFT_W = 3;
  localparam int FRAME_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_CORRECTION = 1'b0,
    REG_NEW_WEIGHT_SHIFT = 1'b1
  } cfg_reg_t;

  localparam logic signed [CFG_DATA_W-1:0] CORR_RESET  = -9'sd121;
  localparam logic [SHIFT_W-1:0]           SHIFT_RESET = 3'd3;
  localparam logic [SM_W-1:0]              PREV_RESET  = 16'd12800;

  // CORDIC datapath: vectors in Q.20, angles in 2^-16 degree
  localparam int XW     = 24;
  localparam int ZW     = 27;
  localparam int AW     = 25;   // angle in [0, full turn)
  localparam int TAB_W  = 5;
  localparam int ATAN_W = 22;

  localparam logic signed [ZW-1:0] FULL_TURN    = 27'sd23592960;
  localparam logic signed [ZW-1:0] HALF_TURN    = 27'sd11796480;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 27'sd5898240;
  localparam logic [AW-1:0]        FULL_TURN_U  = 25'd23592960;
  localparam logic signed [XW-1:0] START_X      = 24'sd636750;

  localparam logic [SM_W:0]    SMOOTH_UNITS = 17'd46080;
  localparam logic [AW:0]      ROUND_HALF   = 26'd256;

  // degree wrap constants
  localparam logic signed [DEG_W+1:0] TURN_DEG_S = 11'sd360;
  localparam logic [DEG_W:0]          TURN_DEG   = 10'd360;
  localparam logic [DEG_W:0]          TWO_TURN_DEG = 10'd720;

  typedef enum logic {
    MODE_ROTATE,
    MODE_VECTOR
  } cordic_mode_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_FOLD,
    C_ITER,
    C_FIN
  } cordic_state_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_DEG,
    T_REL,
    T_NORTH,
    T_ROT_PREV,
    T_WAIT_PREV,
    T_ROT_NEW,
    T_WAIT_NEW,
    T_VEC,
    T_WAIT_VEC,
    T_DONE
  } top_state_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_cmd_t;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [AW-1:0]        angle;
  } cordic_res_t;

  // atan(2^-i) in degrees times 2^16, rounded
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/wvcs_ifs.sv @@
// ----------------------------------------------------------------------------
// wvcs channel interfaces
// Valid/ready channels for the vane sample word and the wind result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvcs_vane_if;
  import wvcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] raw_frame;
  logic [DEG_W-1:0]   boat_heading;

  modport source (output valid, output raw_frame, output boat_heading, input ready);
  modport sink   (input valid, input raw_frame, input boat_heading, output ready);
endinterface

interface wvcs_wind_if;
  import wvcs_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] wind_rel_boat;
  logic [SM_W-1:0]  wind_north_smoothed;

  modport source (output valid, output wind_rel_boat, output wind_north_smoothed, input ready);
  modport sink   (input valid, input wind_rel_boat, input wind_north_smoothed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wvcs_cordic.sv @@
// ----------------------------------------------------------------------------
// wvcs_cordic
// Iterative CORDIC, one micro-rotation per cycle. Rotation mode turns an
// angle into a unit vector; vectoring mode returns the angle of a vector.
// ----------------------------------------------------------------------------
`default_nettype none

module wvcs_cordic #(
  parameter int CORDIC_STEPS = wvcs_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire wvcs_pkg::cordic_cmd_t           cmd,
  input  wire [wvcs_pkg::AW-1:0]               in_angle,
  input  wire logic signed [wvcs_pkg::XW-1:0]  in_x,
  input  wire logic signed [wvcs_pkg::XW-1:0]  in_y,
  output wvcs_pkg::cordic_res_t                res
);
  import wvcs_pkg::*;

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

  cordic_state_t        state, state_next;
  cordic_mode_t         mode, mode_next;
  logic signed [XW-1:0] x, x_next, y, y_next;
  logic signed [ZW-1:0] z, z_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 flip, flip_next;
  logic                 zero, zero_next;
  logic                 done, done_next;
  logic signed [XW-1:0] rx, rx_next, ry, ry_next;
  logic [AW-1:0]        ra, ra_next;

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] a_ext, step_ang, z_wrap;
  logic                 clockwise;

  assign dx       = y >>> cnt;
  assign dy       = x >>> cnt;
  assign a_ext    = signed'({{(ZW-AW){1'b0}}, in_angle});
  assign step_ang = signed'({{(ZW-ATAN_W){1'b0}}, atan_entry(TAB_W'(cnt))});
  assign z_wrap   = (z < 0) ? z + FULL_TURN : z;
  // rotation drives z to zero, vectoring drives y to zero
  assign clockwise = (mode == MODE_ROTATE) ? (z >= 0) : (y < 0);

  always_comb begin
    state_next = state;
    mode_next  = mode;
    x_next     = x;
    y_next     = y;
    z_next     = z;
    cnt_next   = cnt;
    flip_next  = flip;
    zero_next  = zero;
    done_next  = 1'b0;
    rx_next    = rx;
    ry_next    = ry;
    ra_next    = ra;
    case (state)
      C_IDLE: begin
        if (cmd.start) begin
          mode_next = cmd.mode;
          cnt_next  = '0;
          flip_next = 1'b0;
          if (cmd.mode == MODE_ROTATE) begin
            x_next     = START_X;
            y_next     = '0;
            z_next     = (a_ext >= HALF_TURN) ? a_ext - FULL_TURN : a_ext;
            zero_next  = 1'b0;
            state_next = C_FOLD;
          end else begin
            zero_next = (in_x == '0) && (in_y == '0);
            if (in_x < 0) begin
              x_next = -in_x;
              y_next = -in_y;
              z_next = HALF_TURN;
            end else begin
              x_next = in_x;
              y_next = in_y;
              z_next = '0;
            end
            state_next = C_ITER;
          end
        end
      end
      C_FOLD: begin
        // bring the angle into [-90, 90]; the result is negated at the end
        if (z > QUARTER_TURN) begin
          z_next    = z - HALF_TURN;
          flip_next = 1'b1;
        end else if (z < -QUARTER_TURN) begin
          z_next    = z + HALF_TURN;
          flip_next = 1'b1;
        end
        state_next = C_ITER;
      end
      C_ITER: begin
        if (clockwise) begin
          x_next = x - dx;
          y_next = y + dy;
          z_next = z - step_ang;
        end else begin
          x_next = x + dx;
          y_next = y - dy;
          z_next = z + step_ang;
        end
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          state_next = C_FIN;
        end
      end
      C_FIN: begin
        rx_next    = flip ? -x : x;
        ry_next    = flip ? -y : y;
        ra_next    = zero ? '0 : z_wrap[AW-1:0];
        done_next  = 1'b1;
        state_next = C_IDLE;
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    mode <= mode_next;
    x    <= x_next;
    y    <= y_next;
    z    <= z_next;
    cnt  <= cnt_next;
    flip <= flip_next;
    zero <= zero_next;
    rx   <= rx_next;
    ry   <= ry_next;
    ra   <= ra_next;
  end

  assign res.done  = done;
  assign res.x     = rx;
  assign res.y     = ry;
  assign res.angle = ra;

endmodule

`default_nettype wire

@@ rtl/core/wind_vane_circular_smoother.sv @@
// One word is in work at a time: a new vane word is accepted only after
// the previous result word has been loaded into the output register.
// Each word takes three passes through the shared CORDIC unit (two
// rotations, one vectoring).
// Reset: synchronous; registers return to correction -121, shift 3 and a
// stored direction of 100 degrees.
// ----------------------------------------------------------------------------
// wind_vane_circular_smoother
// Vane reading to boat- and north-referenced wind, with exponential
// smoothing of the north direction on unit vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module wind_vane_circular_smoother #(
  parameter int CORDIC_STEPS = wvcs_pkg::CORDIC_STEPS_DEF,
  parameter int ENCODER_BITS = wvcs_pkg::ENCODER_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  wvcs_vane_if.sink                          vane,
  wvcs_wind_if.source                        wind,
  input  wire                                cfg_we,
  input  wire [wvcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [wvcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wvcs_pkg::*;

  localparam int PROD_W = ENCODER_BITS + DEG_W;
  localparam logic [DEG_W-1:0] DEG_SCALE = 9'd360;

  top_state_t state, state_next;

  // configuration
  logic signed [CFG_DATA_W-1:0] angle_correction;
  logic [SHIFT_W-1:0]           new_weight_shift;
  logic [SM_W-1:0]              prev_dir;

  // per-word working registers
  logic [ENCODER_BITS-1:0] code;
  logic [DEG_W-1:0]        heading;
  logic [DEG_W-1:0]        deg;
  logic [DEG_W-1:0]        rel;
  logic [DEG_W-1:0]        north;
  logic signed [XW-1:0]    pc, ps, nc, ns;

  // output register
  logic             out_valid;
  logic [DEG_W-1:0] out_rel;
  logic [SM_W-1:0]  out_sm;

  cordic_cmd_t          ccmd;
  cordic_res_t          cres;
  logic [AW-1:0]        c_angle;
  logic signed [XW-1:0] c_x, c_y;

  logic [PROD_W-1:0]       prod;
  logic signed [DEG_W+1:0] rel_sum;
  logic [DEG_W:0]          north_sum;
  logic [AW-1:0]           prev_ext;
  logic [AW-1:0]           prev_angle;
  logic [AW:0]             sm_round;
  logic [SM_W:0]           sm_q;
  logic [SM_W-1:0]         sm;
  logic                    accept, load_out;

  assign accept   = vane.valid && vane.ready;
  assign load_out = (state == T_DONE) && (!out_valid || wind.ready);

  assign prod    = PROD_W'(code) * PROD_W'(DEG_SCALE);
  assign rel_sum = signed'({2'b00, deg}) + {{2{angle_correction[CFG_DATA_W-1]}}, angle_correction};
  assign north_sum = {1'b0, rel} + {1'b0, heading};

  // stored direction in 1/128 degree to 2^-16 degree
  assign prev_ext   = {prev_dir, 9'b0};
  assign prev_angle = (prev_ext >= FULL_TURN_U) ? prev_ext - FULL_TURN_U : prev_ext;

  assign sm_round = {1'b0, cres.angle} + ROUND_HALF;
  assign sm_q     = sm_round[AW:9];
  assign sm       = (sm_q >= SMOOTH_UNITS) ? '0 : sm_q[SM_W-1:0];

  // sequencer
  always_comb begin
    state_next = state;
    ccmd.start = 1'b0;
    ccmd.mode  = MODE_ROTATE;
    c_angle    = prev_angle;
    c_x        = pc + (nc >>> new_weight_shift);
    c_y        = ps + (ns >>> new_weight_shift);
    case (state)
      T_IDLE: begin
        if (accept) begin
          state_next = T_DEG;
        end
      end
      T_DEG:   state_next = T_REL;
      T_REL:   state_next = T_NORTH;
      T_NORTH: state_next = T_ROT_PREV;
      T_ROT_PREV: begin
        ccmd.start = 1'b1;
        state_next = T_WAIT_PREV;
      end
      T_WAIT_PREV: begin
        if (cres.done) begin
          state_next = T_ROT_NEW;
        end
      end
      T_ROT_NEW: begin
        ccmd.start = 1'b1;
        c_angle    = {north, 16'b0};
        state_next = T_WAIT_NEW;
      end
      T_WAIT_NEW: begin
        if (cres.done) begin
          state_next = T_VEC;
        end
      end
      T_VEC: begin
        ccmd.start = 1'b1;
        ccmd.mode  = MODE_VECTOR;
        state_next = T_WAIT_VEC;
      end
      T_WAIT_VEC: begin
        if (cres.done) begin
          state_next = T_DONE;
        end
      end
      T_DONE: begin
        if (load_out) begin
          state_next = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_correction <= CORR_RESET;
      new_weight_shift <= SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_CORRECTION: angle_correction <= signed'(cfg_data);
        REG_NEW_WEIGHT_SHIFT: new_weight_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dir <= PREV_RESET;
    end else if (load_out) begin
      prev_dir <= sm;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code    <= vane.raw_frame[ENCODER_BITS-1:0];
      heading <= vane.boat_heading;
    end
    if (state == T_DEG) begin
      deg <= prod[PROD_W-1:ENCODER_BITS];
    end
    if (state == T_REL) begin
      if (rel_sum < 0) begin
        rel <= DEG_W'(rel_sum + TURN_DEG_S);
      end else if (rel_sum >= TURN_DEG_S) begin
        rel <= DEG_W'(rel_sum - TURN_DEG_S);
      end else begin
        rel <= DEG_W'(rel_sum);
      end
    end
    if (state == T_NORTH) begin
      if (north_sum >= TWO_TURN_DEG) begin
        north <= DEG_W'(north_sum - TWO_TURN_DEG);
      end else if (north_sum >= TURN_DEG) begin
        north <= DEG_W'(north_sum - TURN_DEG);
      end else begin
        north <= north_sum[DEG_W-1:0];
      end
    end
    if (state == T_WAIT_PREV && cres.done) begin
      pc <= cres.x;
      ps <= cres.y;
    end
    if (state == T_WAIT_NEW && cres.done) begin
      nc <= cres.x;
      ns <= cres.y;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (wind.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rel <= rel;
      out_sm  <= sm;
    end
  end

  wvcs_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ccmd),
    .in_angle (c_angle),
    .in_x     (c_x),
    .in_y     (c_y),
    .res      (cres)
  );

  assign vane.ready               = (state == T_IDLE);
  assign wind.valid               = out_valid;
  assign wind.wind_rel_boat       = out_rel;
  assign wind.wind_north_smoothed = out_sm;

`ifndef SYNTHESIS
  a_prev_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, prev_dir} < SMOOTH_UNITS)
    else $error("stored direction out of range");

  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_sm} < SMOOTH_UNITS && {1'b0, out_rel} < TURN_DEG))
    else $error("result word out of range");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> (state == T_WAIT_PREV || state == T_WAIT_NEW || state == T_WAIT_VEC))
    else $error("cordic result with no pass pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !vane.ready)
    else $error("accepted a word while busy");
`endif

endmodule

`default_nettype wire
